// ===== hdl/lsia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack package
// Shared sizes, codes and request/result/control types for the stack block.
// ----------------------------------------------------------------------------
package lsia_pkg;

    // Storage sizes.
    localparam int DEPTH      = 64;
    localparam int WORD_BITS  = 32;
    localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    // Action codes.
    localparam logic [2:0] ACT_PUSH  = 3'd0;
    localparam logic [2:0] ACT_POP   = 3'd1;
    localparam logic [2:0] ACT_PEEK  = 3'd2;
    localparam logic [2:0] ACT_READN = 3'd3;
    localparam logic [2:0] ACT_SWAP  = 3'd4;

    // Status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_UNDER = 2'd1;
    localparam logic [1:0] STATUS_OVER  = 2'd2;
    localparam logic [1:0] STATUS_RANGE = 2'd3;

    // One request.
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] push_value;
        logic [5:0]  index_a;
        logic [5:0]  index_b;
    } req_t;

    // One result.
    typedef struct packed {
        logic [31:0] read_data;
        logic        data_valid;
        logic [1:0]  status;
        logic [6:0]  stored_count;
        logic        is_empty;
    } rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SWAP_A,
        S_SWAP_B
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic mem_read;
        logic push_wr;
        logic swap_wr_a;
        logic swap_wr_b;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ok;
        logic is_push;
        logic is_read;
        logic is_swap;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/lsia_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack controller
// Sequences each request through decode, memory read and swap write cycles.
// ----------------------------------------------------------------------------
module lsia_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lsia_pkg::dp_stat_t dp_stat,
    output lsia_pkg::cmd_t         cmd,
    output logic                   busy
);
    import lsia_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (dp_stat.ok && dp_stat.is_read)
                begin
                    state_next = S_READ;
                end
                else if (dp_stat.ok && dp_stat.is_swap)
                begin
                    state_next = S_SWAP_A;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:   state_next = S_IDLE;
            S_SWAP_A: state_next = S_SWAP_B;
            S_SWAP_B: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
            end
            S_EXEC:
            begin
                cmd.mem_read = 1'b1;
                cmd.push_wr  = dp_stat.ok && dp_stat.is_push;
                cmd.finish   = !(dp_stat.ok && (dp_stat.is_read || dp_stat.is_swap));
            end
            S_READ:
            begin
                cmd.finish = 1'b1;
            end
            S_SWAP_A:
            begin
                cmd.swap_wr_a = 1'b1;
            end
            S_SWAP_B:
            begin
                cmd.swap_wr_b = 1'b1;
                cmd.finish    = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/lsia_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack datapath
// Holds the request, the entry memory, the word count and the result register.
// ----------------------------------------------------------------------------
module lsia_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lsia_pkg::req_t  request,
    input  wire lsia_pkg::cmd_t  cmd,
    output lsia_pkg::dp_stat_t   dp_stat,
    output lsia_pkg::rsp_t       result,
    output logic                 done
);
    import lsia_pkg::*;

    req_t   req_reg;
    count_t count_reg;
    count_t count_next;
    word_t  rd_a_reg;
    word_t  rd_b_reg;
    rsp_t   result_reg;
    logic   done_reg;
    word_t  mem [DEPTH];

    logic        is_push;
    logic        is_pop;
    logic        is_peek;
    logic        is_readn;
    logic        is_swap;
    logic        is_full;
    logic        is_zero;
    logic        a_out;
    logic        b_out;
    logic [1:0]  status;
    logic [5:0]  depth_sel;
    logic [31:0] top_pos;
    addr_t       raddr_a;
    addr_t       raddr_b;
    logic        mem_we;
    addr_t       waddr;
    word_t       wdata;

    // Request register.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
    end

    // Decode and checks against the current count.
    always_comb
    begin
        is_push  = (req_reg.action == ACT_PUSH);
        is_pop   = (req_reg.action == ACT_POP);
        is_peek  = (req_reg.action == ACT_PEEK);
        is_readn = (req_reg.action == ACT_READN);
        is_swap  = (req_reg.action == ACT_SWAP);
        is_full  = (32'(count_reg) >= 32'(DEPTH));
        is_zero  = (count_reg == '0);
        a_out    = (32'(req_reg.index_a) >= 32'(count_reg));
        b_out    = (32'(req_reg.index_b) >= 32'(count_reg));
        status   = STATUS_OK;
        if (is_push && is_full)
        begin
            status = STATUS_OVER;
        end
        else if ((is_pop || is_peek) && is_zero)
        begin
            status = STATUS_UNDER;
        end
        else if ((is_readn && a_out) || (is_swap && (a_out || b_out)))
        begin
            status = STATUS_RANGE;
        end
        dp_stat.ok      = (status == STATUS_OK);
        dp_stat.is_push = is_push;
        dp_stat.is_read = is_pop || is_peek || is_readn;
        dp_stat.is_swap = is_swap;
    end

    // Read addresses: a word below the top, or the two swap positions.
    always_comb
    begin
        depth_sel = is_readn ? req_reg.index_a : 6'd0;
        top_pos   = 32'(count_reg) - 32'd1 - 32'(depth_sel);
        if (is_swap)
        begin
            raddr_a = addr_t'(req_reg.index_a);
        end
        else
        begin
            raddr_a = top_pos[ADDR_BITS-1:0];
        end
        raddr_b = addr_t'(req_reg.index_b);
    end

    // Single write port: push on top, or the two halves of a swap.
    always_comb
    begin
        mem_we = cmd.push_wr || cmd.swap_wr_a || cmd.swap_wr_b;
        waddr  = count_reg[ADDR_BITS-1:0];
        wdata  = word_t'(req_reg.push_value);
        if (cmd.swap_wr_a)
        begin
            waddr = addr_t'(req_reg.index_a);
            wdata = rd_b_reg;
        end
        else if (cmd.swap_wr_b)
        begin
            waddr = addr_t'(req_reg.index_b);
            wdata = rd_a_reg;
        end
    end

    // Entry memory with two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_read)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    // Word count update.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push_wr)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (cmd.finish && is_pop && dp_stat.ok)
        begin
            count_next = count_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result_reg.data_valid   <= dp_stat.ok && dp_stat.is_read;
            result_reg.read_data    <= (dp_stat.ok && dp_stat.is_read) ?
                                       32'(rd_a_reg) : 32'd0;
            result_reg.status       <= status;
            result_reg.stored_count <= 7'(count_next);
            result_reg.is_empty     <= (count_next == '0);
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

// ===== hdl/lifo_stack_with_indexed_access.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Each accepted request goes to EXEC, where push, error and no-op requests finish;
// pop, peek and read-nth then pass through READ, swap through SWAP_A and SWAP_B.
// The done strobe is registered after the finishing state. A new request is taken
// only while idle, as in the cycle that done is high. Swap uses the single write port twice.
// Reset clears the word count and the controller; stored words are not cleared.
// ----------------------------------------------------------------------------
// LIFO stack with indexed access
// Fixed-depth stack with push, pop, peek, read-nth and swap requests.
// ----------------------------------------------------------------------------
module lifo_stack_with_indexed_access (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire lsia_pkg::req_t request,
    output logic                busy,
    output logic                done,
    output lsia_pkg::rsp_t      result
);
    import lsia_pkg::*;

    cmd_t     cmd;
    dp_stat_t dp_stat;

    // Controller.
    lsia_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // Datapath.
    lsia_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .dp_stat (dp_stat),
        .result  (result),
        .done    (done)
    );

endmodule
`default_nettype wire

// ===== hdl/lsia_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LIFO stack port checker
// Checks request acceptance and result strobe behavior on the top-level ports.
// ----------------------------------------------------------------------------
module lsia_checker (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           busy,
    input  wire logic           done,
    input  wire lsia_pkg::rsp_t result
);
    import lsia_pkg::*;

    // An accepted request makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an accepted request");

    // The result strobe never comes in the cycle after acceptance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result strobe right after acceptance");

    // A result is shown only once the block can take a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // The empty flag agrees with the word count.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.stored_count == 7'd0)))
        else $error("empty flag disagrees with count");

    // Data without the valid flag reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.data_valid) |-> (result.read_data == 32'd0))
        else $error("nonzero data without valid flag");

endmodule

bind lifo_stack_with_indexed_access lsia_checker u_lsia_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire
